>>> rtl/sorted_timer_event_queue_defines.svh
// ----------------------------------------------------------------------------
// Sorted timer event queue: assertion macros
// Shorthand for the clocked, reset-gated properties that the checker uses.
// ----------------------------------------------------------------------------
`ifndef SORTED_TIMER_EVENT_QUEUE_DEFINES_SVH
`define SORTED_TIMER_EVENT_QUEUE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define STQ_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define STQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/stq_pkg.sv
// ----------------------------------------------------------------------------
// Sorted timer event queue package
// Sizes, command and result codes, and the types shared by the queue cells.
// ----------------------------------------------------------------------------
package stq_pkg;

  localparam int DEPTH        = 16;
  localparam int DISPATCH_MAX = 16;
  localparam int TIME_W       = 32;
  localparam int ID_W         = 16;
  localparam int WAIT_W       = 42;
  localparam int DCNT_W       = $clog2(DISPATCH_MAX + 1);

  typedef enum logic [1:0] {
    CMD_INSERT    = 2'd0,
    CMD_REMOVE    = 2'd1,
    CMD_DISCHARGE = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    KIND_INSERT   = 2'd0,
    KIND_REMOVE   = 2'd1,
    KIND_DISPATCH = 2'd2,
    KIND_SUMMARY  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    OP_HOLD   = 2'd0,
    OP_INSERT = 2'd1,
    OP_REMOVE = 2'd2,
    OP_POP    = 2'd3
  } cell_op_t;

  typedef struct packed {
    logic              valid;
    logic [TIME_W-1:0] due;
    logic [ID_W-1:0]   id;
  } slot_t;

  typedef struct packed {
    cell_op_t          op;
    logic [TIME_W-1:0] due;
    logic [ID_W-1:0]   new_id;
    logic [ID_W-1:0]   rid;
  } cell_ctl_t;

  localparam slot_t SLOT_EMPTY = '{valid: 1'b0, due: '0, id: '0};

endpackage

>>> rtl/sorted_timer_event_queue.sv
// ----------------------------------------------------------------------------
// Sorted timer event queue
// Pending events kept in due-time order in a row of cells; insert, remove
// by id, and discharge of due events with the wait to the next one.
// ----------------------------------------------------------------------------
// Usage:
//   A request is taken at a rising edge with start high and busy low.
//   command selects insert (due_time), remove (entry_id) or discharge
//   (now_time); command code 3 is ignored.
//   Results appear on kind/event_id/status/none_pending/wait_ms/last for one
//   cycle each, marked by result_valid; last flags the final one of a request.
//   Insert and remove: one result, in the cycle after the request; busy stays
//   low, so a new request may follow in the next cycle.
//   Discharge: busy until the summary is registered; due events are
//   dispatched one per cycle, capped at DISPATCH_MAX; each dispatched id is
//   registered as its event pops, then ST_DISP hands over to ST_SUM for the summary.
//   The head cell sets the pop rate: one pop per cycle through the row.
//   The summary's wait is built from shifts and subtracts in its own cycle.
//   Reset empties the queue and sets the next id to zero; there is no
//   clearing pass. The receiver cannot stall; results are never held.
// ----------------------------------------------------------------------------
module sorted_timer_event_queue (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    command,
  input  logic [stq_pkg::TIME_W-1:0]    due_time,
  input  logic [stq_pkg::ID_W-1:0]      entry_id,
  input  logic [stq_pkg::TIME_W-1:0]    now_time,
  output logic                          result_valid,
  output logic [1:0]                    kind,
  output logic [stq_pkg::ID_W-1:0]      event_id,
  output logic                          status,
  output logic                          none_pending,
  output logic [stq_pkg::WAIT_W-1:0]    wait_ms,
  output logic                          last
);
  import stq_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DISP,
    ST_SUM
  } state_t;

  state_t              state;
  logic [ID_W-1:0]     next_id;
  logic [TIME_W-1:0]   now_reg;
  logic [DCNT_W-1:0]   disp_cnt;
  logic [TIME_W-1:0]   diff_reg;
  logic                none_reg;

  slot_t               slots [DEPTH];
  logic [DEPTH-1:0]    stay;
  logic [DEPTH-1:0]    found;

  cell_ctl_t           ctl;
  logic                accept;
  logic                full;
  logic                can_pop;
  logic [WAIT_W-1:0]   diff_wide;
  logic [WAIT_W-1:0]   wait_calc;

  assign busy    = (state != ST_IDLE);
  assign accept  = start && !busy;
  assign full    = slots[DEPTH-1].valid;
  assign can_pop = (state == ST_DISP) && slots[0].valid &&
                   (slots[0].due <= now_reg) &&
                   (disp_cnt < DCNT_W'(DISPATCH_MAX));

  // x * 1000 = x * 1024 - x * 16 - x * 8
  assign diff_wide = WAIT_W'(diff_reg);
  assign wait_calc = (diff_wide << 10) - (diff_wide << 4) - (diff_wide << 3);

  always_comb begin
    ctl.op     = OP_HOLD;
    ctl.due    = due_time;
    ctl.new_id = next_id;
    ctl.rid    = entry_id;
    if (accept && (command == CMD_INSERT) && !full) begin
      ctl.op = OP_INSERT;
    end else if (accept && (command == CMD_REMOVE)) begin
      ctl.op = OP_REMOVE;
    end else if (can_pop) begin
      ctl.op = OP_POP;
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    slot_t left_slot;
    slot_t right_slot;
    logic  left_stay;
    logic  found_in;

    if (i == 0) begin : g_head
      assign left_slot = SLOT_EMPTY;
      assign left_stay = 1'b1;
      assign found_in  = 1'b0;
    end else begin : g_body
      assign left_slot = slots[i-1];
      assign left_stay = stay[i-1];
      assign found_in  = found[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign right_slot = SLOT_EMPTY;
    end else begin : g_inner
      assign right_slot = slots[i+1];
    end

    stq_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctl       (ctl),
      .left      (left_slot),
      .left_stay (left_stay),
      .found_in  (found_in),
      .right     (right_slot),
      .cur       (slots[i]),
      .stay      (stay[i]),
      .found_out (found[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      next_id      <= '0;
      disp_cnt     <= '0;
      result_valid <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (accept) begin
            case (command)
              CMD_INSERT: begin
                result_valid <= 1'b1;
                kind         <= KIND_INSERT;
                none_pending <= 1'b0;
                wait_ms      <= '0;
                last         <= 1'b1;
                if (full) begin
                  event_id <= '0;
                  status   <= 1'b1;
                end else begin
                  event_id <= next_id;
                  status   <= 1'b0;
                  next_id  <= next_id + 1'b1;
                end
              end
              CMD_REMOVE: begin
                result_valid <= 1'b1;
                kind         <= KIND_REMOVE;
                event_id     <= '0;
                status       <= !found[DEPTH-1];
                none_pending <= 1'b0;
                wait_ms      <= '0;
                last         <= 1'b1;
              end
              CMD_DISCHARGE: begin
                now_reg  <= now_time;
                disp_cnt <= '0;
                state    <= ST_DISP;
              end
              default: ;
            endcase
          end
        end
        ST_DISP: begin
          if (can_pop) begin
            result_valid <= 1'b1;
            kind         <= KIND_DISPATCH;
            event_id     <= slots[0].id;
            status       <= 1'b0;
            none_pending <= 1'b0;
            wait_ms      <= '0;
            last         <= 1'b0;
            disp_cnt     <= disp_cnt + 1'b1;
          end else begin
            // A head still due here means the dispatch cap was hit: wait 0.
            if (slots[0].valid && (slots[0].due > now_reg)) begin
              diff_reg <= slots[0].due - now_reg;
            end else begin
              diff_reg <= '0;
            end
            none_reg <= !slots[0].valid;
            state    <= ST_SUM;
          end
        end
        ST_SUM: begin
          result_valid <= 1'b1;
          kind         <= KIND_SUMMARY;
          event_id     <= '0;
          status       <= 1'b0;
          none_pending <= none_reg;
          wait_ms      <= wait_calc;
          last         <= 1'b1;
          state        <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

>>> rtl/stq_cell.sv
// ----------------------------------------------------------------------------
// Sorted timer event queue: one queue cell
// Holds one pending event and trades it with its neighbors on insert,
// remove and pop, so the row stays sorted by due time.
// ----------------------------------------------------------------------------
module stq_cell (
  input  logic              clk,
  input  logic              rst,
  input  stq_pkg::cell_ctl_t ctl,
  input  stq_pkg::slot_t    left,
  input  logic              left_stay,
  input  logic              found_in,
  input  stq_pkg::slot_t    right,
  output stq_pkg::slot_t    cur,
  output logic              stay,
  output logic              found_out
);
  import stq_pkg::*;

  slot_t cur_next;
  logic  match;

  // Equal due times stay ahead of a new event, keeping insertion order.
  assign stay      = cur.valid && (cur.due <= ctl.due);
  assign match     = cur.valid && (cur.id == ctl.rid);
  assign found_out = found_in | match;

  always_comb begin
    cur_next = cur;
    case (ctl.op)
      OP_INSERT: begin
        if (!stay) begin
          if (left_stay) begin
            cur_next = '{valid: 1'b1, due: ctl.due, id: ctl.new_id};
          end else begin
            cur_next = left;
          end
        end
      end
      // Close the gap from the earliest match onward.
      OP_REMOVE: begin
        if (found_out) begin
          cur_next = right;
        end
      end
      OP_POP:  cur_next = right;
      default: cur_next = cur;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur.valid <= 1'b0;
    end else begin
      cur <= cur_next;
    end
  end

endmodule

>>> rtl/stq_checker.sv
// ----------------------------------------------------------------------------
// Sorted timer event queue: port checker
// Watches the request and result ports and flags sequencing errors.
// ----------------------------------------------------------------------------
`include "sorted_timer_event_queue_defines.svh"

module stq_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       start,
  input logic                       busy,
  input logic [1:0]                 command,
  input logic                       result_valid,
  input logic [1:0]                 kind,
  input logic [stq_pkg::ID_W-1:0]   event_id,
  input logic                       status,
  input logic                       last
);
  import stq_pkg::*;

  `STQ_ASSERT_NEXT(a_insert_reply, start && !busy && command == CMD_INSERT, result_valid && kind == KIND_INSERT && last, "insert request without a reply in the next cycle")
  `STQ_ASSERT_NEXT(a_discharge_busy, start && !busy && command == CMD_DISCHARGE, busy, "discharge request did not raise busy")
  `STQ_ASSERT_NOW(a_dispatch_not_last, result_valid && kind == KIND_DISPATCH, !last, "dispatched event marked last")
  `STQ_ASSERT_NOW(a_summary_ends, result_valid && kind == KIND_SUMMARY, last && !busy && event_id == '0, "summary not final or queue still busy")
  `STQ_ASSERT_NOW(a_full_no_id, result_valid && kind == KIND_INSERT && status, event_id == '0, "full insert reply carries an id")

endmodule

bind sorted_timer_event_queue stq_checker u_stq_checker (.*);
